FILE: rtl/fdfp_pkg.sv
// Shared types and constants of the flip-dot frame packer.
// No dependencies; the core, register file, sequencer and testbench import this package.
package fdfp_pkg;

  // Operation codes of an input beat
  typedef logic [1:0] op_t;
  localparam op_t OP_PIXEL  = 2'd0;
  localparam op_t OP_BRIGHT = 2'd1;
  localparam op_t OP_DARK   = 2'd2;

  // Packet framing bytes
  localparam logic [7:0] HDR0      = 8'h80;
  localparam logic [7:0] HDR1      = 8'h83;
  localparam logic [7:0] TRAILER   = 8'h8F;
  localparam logic [7:0] BROADCAST = 8'hFF;

  // Configuration register indexes and reset values
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_INVERT     = 2'd0;
  localparam reg_idx_t REG_UPPER_ADDR = 2'd1;
  localparam reg_idx_t REG_LOWER_ADDR = 2'd2;

  localparam logic [7:0] UPPER_ADDR_RST = 8'd21;
  localparam logic [7:0] LOWER_ADDR_RST = 8'd23;

  // Beat payloads
  typedef struct packed {
    op_t        operation;
    logic [7:0] pixel_value;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Register values seen by the datapath
  typedef struct packed {
    logic       invert;
    logic [7:0] upper_addr;
    logic [7:0] lower_addr;
  } cfg_t;

  // Request to the packet sequencer
  typedef struct packed {
    logic go;
    logic fill;
    logic bright;
  } start_t;

endpackage

FILE: rtl/fdfp_stream_if.sv
// Valid/ready stream channel used for the input and result beats.
// Payload type is a parameter; the block uses the structs of fdfp_pkg.
interface fdfp_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/flip_dot_frame_packer_core.sv
// Flip-dot frame packer: takes a COLUMNS x 2*PANEL_ROWS frame one pixel beat
// per cycle while idle, in row-major order, and packs it into column bitmaps of
// an upper and a lower panel. The frame's last pixel starts two packets (0x80,
// 0x83, address, COLUMNS column bytes, 0x8F) and the input stays not ready
// until their last byte is loaded; a fill command sends one broadcast packet.
// Packets come from the single packet sequencer, which loads one byte a cycle
// into the output register unless the sink stalls.
// Bitmaps and pixel position clear after the frame's packets.
module flip_dot_frame_packer_core #(
  parameter int COLUMNS    = 28,
  parameter int PANEL_ROWS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  fdfp_stream_if.sink  in_ch,
  fdfp_stream_if.source out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import fdfp_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  cfg_t                  cfg;
  start_t                start;
  in_item_t              item;
  out_item_t             out_item;
  logic                  in_acc;
  logic                  idle;
  logic                  clear;
  logic                  pix_we;
  logic                  pix_on;
  logic                  rd_panel;
  logic [COL_W-1:0]      rd_col;
  logic [PANEL_ROWS-1:0] rd_data;

  fdfp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign item        = in_ch.data;
  assign in_ch.ready = idle;
  assign in_acc      = in_ch.valid && idle;
  assign pix_we      = in_acc && (item.operation == OP_PIXEL);
  assign pix_on      = (item.pixel_value != 8'd0) ^ cfg.invert;

  always_comb begin
    start = '0;
    if (in_acc) begin
      unique case (item.operation)
        OP_PIXEL: start.go = item.last_pixel;
        OP_BRIGHT: begin
          start.go     = 1'b1;
          start.fill   = 1'b1;
          start.bright = 1'b1;
        end
        OP_DARK: begin
          start.go   = 1'b1;
          start.fill = 1'b1;
        end
        default: start = '0;
      endcase
    end
  end

  fdfp_bitmap #(
    .COLUMNS    (COLUMNS),
    .PANEL_ROWS (PANEL_ROWS)
  ) u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_we   (pix_we),
    .pix_on   (pix_on),
    .clear    (clear),
    .rd_panel (rd_panel),
    .rd_col   (rd_col),
    .rd_data  (rd_data)
  );

  fdfp_emit #(
    .COLUMNS    (COLUMNS),
    .PANEL_ROWS (PANEL_ROWS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg       (cfg),
    .rd_panel  (rd_panel),
    .rd_col    (rd_col),
    .rd_data   (rd_data),
    .idle      (idle),
    .clear     (clear),
    .out_valid (out_ch.valid),
    .out_data  (out_item),
    .out_ready (out_ch.ready)
  );

  assign out_ch.data = out_item;

endmodule

FILE: rtl/fdfp_cfg.sv
// APB-style register file: invert flag and the two panel addresses.
// Depends on fdfp_pkg for register indexes, reset values and cfg_t.
module fdfp_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output fdfp_pkg::cfg_t cfg
);
  import fdfp_pkg::*;

  logic       invert_r;
  logic [7:0] upper_addr_r;
  logic [7:0] lower_addr_r;
  logic       wr_en;
  reg_idx_t   idx;

  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r     <= 1'b0;
      upper_addr_r <= UPPER_ADDR_RST;
      lower_addr_r <= LOWER_ADDR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_INVERT:     invert_r     <= cfg_pwdata[0];
        REG_UPPER_ADDR: upper_addr_r <= cfg_pwdata[7:0];
        REG_LOWER_ADDR: lower_addr_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INVERT:     cfg_prdata = {31'd0, invert_r};
      REG_UPPER_ADDR: cfg_prdata = {24'd0, upper_addr_r};
      REG_LOWER_ADDR: cfg_prdata = {24'd0, lower_addr_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.invert     = invert_r;
  assign cfg.upper_addr = upper_addr_r;
  assign cfg.lower_addr = lower_addr_r;

endmodule

FILE: rtl/fdfp_bitmap.sv
// Column bitmaps of both panels plus the row/column pixel position.
// Sets one dot per lit pixel within the frame; one column read port for the sequencer.
module fdfp_bitmap #(
  parameter int COLUMNS    = 28,
  parameter int PANEL_ROWS = 7,
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
  localparam int ROW_W     = $clog2(2 * PANEL_ROWS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pix_we,
  input  logic                  pix_on,
  input  logic                  clear,
  input  logic                  rd_panel,
  input  logic [COL_W-1:0]      rd_col,
  output logic [PANEL_ROWS-1:0] rd_data
);
  localparam logic [ROW_W-1:0] ROW_FULL = ROW_W'(2 * PANEL_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  logic [PANEL_ROWS-1:0] upper_r [COLUMNS];
  logic [PANEL_ROWS-1:0] lower_r [COLUMNS];
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic                  full;
  logic                  set_dot;

  // Pixels past the frame are dropped and the position saturates
  assign full    = (row_r == ROW_FULL);
  assign set_dot = pix_we && pix_on && !full;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      col_r <= '0;
      row_r <= '0;
    end else if (pix_we && !full) begin
      if (col_r == COL_LAST) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < COLUMNS; c++) begin
      for (int r = 0; r < PANEL_ROWS; r++) begin
        if (!rst_n || clear) begin
          upper_r[c][r] <= 1'b0;
          lower_r[c][r] <= 1'b0;
        end else if (set_dot && col_r == COL_W'(c)) begin
          if (row_r == ROW_W'(r)) upper_r[c][r] <= 1'b1;
          if (row_r == ROW_W'(r + PANEL_ROWS)) lower_r[c][r] <= 1'b1;
        end
      end
    end
  end

  assign rd_data = rd_panel ? lower_r[rd_col] : upper_r[rd_col];

endmodule

FILE: rtl/fdfp_emit.sv
// Packet sequencer: one position counter walks header, address, columns
// and trailer, loading one byte per step into the output register.
module fdfp_emit #(
  parameter int COLUMNS    = 28,
  parameter int PANEL_ROWS = 7,
  localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fdfp_pkg::start_t       start,
  input  fdfp_pkg::cfg_t         cfg,
  output logic                   rd_panel,
  output logic [COL_W-1:0]       rd_col,
  input  logic [PANEL_ROWS-1:0]  rd_data,
  output logic                   idle,
  output logic                   clear,
  output logic                   out_valid,
  output fdfp_pkg::out_item_t    out_data,
  input  logic                   out_ready
);
  import fdfp_pkg::*;

  localparam int POS_W = $clog2(COLUMNS + 4);
  localparam logic [POS_W-1:0] POS_HDR0  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(COLUMNS + 3);
  localparam logic [7:0]       FILL_ON   = 8'((1 << PANEL_ROWS) - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r;
  logic [POS_W-1:0] pos_r;
  logic             pkt_r;
  logic             fill_r;
  logic             bright_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             step;
  logic             at_end;
  logic [7:0]       byte_nxt;
  logic [7:0]       addr;

  // Advance only when the output register is free or being emptied
  assign step     = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign at_end   = (pos_r == POS_LAST) && (fill_r || pkt_r);
  assign rd_panel = pkt_r;
  assign rd_col   = COL_W'(pos_r - POS_ADDR - POS_W'(1));
  assign addr     = fill_r ? BROADCAST : (pkt_r ? cfg.lower_addr : cfg.upper_addr);

  always_comb begin
    if (pos_r == POS_HDR0)      byte_nxt = HDR0;
    else if (pos_r == POS_HDR1) byte_nxt = HDR1;
    else if (pos_r == POS_ADDR) byte_nxt = addr;
    else if (pos_r == POS_LAST) byte_nxt = TRAILER;
    else if (fill_r)            byte_nxt = bright_r ? FILL_ON : 8'd0;
    else                        byte_nxt = 8'(rd_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      pkt_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start.go) begin
            state_r  <= ST_RUN;
            pos_r    <= '0;
            pkt_r    <= 1'b0;
            fill_r   <= start.fill;
            bright_r <= start.bright;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (pos_r == POS_LAST) begin
              pos_r <= '0;
              pkt_r <= 1'b1;
              if (fill_r || pkt_r) state_r <= ST_IDLE;
            end else begin
              pos_r <= pos_r + POS_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (step) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= byte_nxt;
        out_last_r  <= at_end;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Drop the frame bitmaps once the lower panel's trailer is loaded
  assign clear              = step && at_end && !fill_r;
  assign idle               = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_data.out_byte  = out_byte_r;
  assign out_data.last_byte = out_last_r;

endmodule

FILE: dv/tb_flip_dot_frame_packer_core.sv
// Self-checking testbench of flip_dot_frame_packer_core: directed table, then random frames.
// Needs fdfp_pkg and fdfp_stream_if; predicts bytes from its own bitmap copy or typed rows.
`timescale 1ns / 100ps

module tb_flip_dot_frame_packer_core;
  import fdfp_pkg::*;

  localparam int NUM_COLS     = 28;
  localparam int PANEL_HEIGHT = 7;
  localparam int FRAME_PIXELS = NUM_COLS * 2 * PANEL_HEIGHT;
  localparam logic [6:0] FULL_COLUMN = 7'h7F;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 18;

  // One directed beat; typed rows carry their expected packets spelled out
  typedef struct packed {
    in_item_t    item;
    logic        typed;
    logic [1:0]  packets;
    logic [7:0]  addr0;
    logic [7:0]  addr1;
    logic [6:0]  col;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  fdfp_stream_if #(.data_t(in_item_t)) in_if ();
  fdfp_stream_if #(.data_t(out_item_t)) out_if ();

  flip_dot_frame_packer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copy
  logic [6:0]  upper_bitmap [NUM_COLS];
  logic [6:0]  lower_bitmap [NUM_COLS];
  int unsigned pixel_pos;
  logic        set_invert = 1'b0;
  logic [7:0]  set_upper_addr = UPPER_ADDR_RST;
  logic [7:0]  set_lower_addr = LOWER_ADDR_RST;

  out_item_t   item_beats [$];
  out_item_t   expected_beats [$];

  bit          no_idle = 1'b0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned frames_packed = 0;
  int unsigned fills_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned settings_used = 1;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{OP_BRIGHT, 8'hFF, 1'b1}, 1'b1, 2'd1, BROADCAST, 8'h00, FULL_COLUMN},
    '{'{OP_DARK,   8'hAA, 1'b1}, 1'b1, 2'd1, BROADCAST, 8'h00, 7'h00},
    '{'{OP_UNUSED, 8'hFF, 1'b1}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h00, 1'b1}, 1'b1, 2'd2, UPPER_ADDR_RST, LOWER_ADDR_RST, 7'h00},
    '{'{OP_PIXEL,  8'hFF, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h01, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h80, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h00, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_BRIGHT, 8'h00, 1'b0}, 1'b1, 2'd1, BROADCAST, 8'h00, FULL_COLUMN},
    '{'{OP_UNUSED, 8'h00, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_DARK,   8'h55, 1'b1}, 1'b1, 2'd1, BROADCAST, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h7F, 1'b0}, 1'b0, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h02, 1'b1}, 1'b0, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h04, 1'b1}, 1'b0, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h08, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h10, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h20, 1'b0}, 1'b1, 2'd0, 8'h00, 8'h00, 7'h00},
    '{'{OP_PIXEL,  8'h40, 1'b1}, 1'b0, 2'd0, 8'h00, 8'h00, 7'h00}
  };

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] draw_pixel();
    return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  function automatic void add_packet(input logic [7:0] addr, input logic [6:0] cols [NUM_COLS]);
    item_beats.push_back(out_item_t'{HDR0, 1'b0});
    item_beats.push_back(out_item_t'{HDR1, 1'b0});
    item_beats.push_back(out_item_t'{addr, 1'b0});
    foreach (cols[c]) item_beats.push_back(out_item_t'{{1'b0, cols[c]}, 1'b0});
    item_beats.push_back(out_item_t'{TRAILER, 1'b0});
  endfunction

  // Update the bitmaps for one beat and list the packet bytes it causes
  function automatic void encode_item(input in_item_t it);
    logic [6:0]  flat [NUM_COLS];
    int unsigned r;
    int unsigned c;
    logic        lit;
    item_beats.delete();
    case (it.operation)
      OP_BRIGHT, OP_DARK: begin
        foreach (flat[i]) flat[i] = (it.operation == OP_BRIGHT) ? FULL_COLUMN : 7'h00;
        add_packet(BROADCAST, flat);
        fills_sent++;
      end
      OP_PIXEL: begin
        // drop pixels past the end of the frame
        if (pixel_pos < FRAME_PIXELS) begin
          r = pixel_pos / NUM_COLS;
          c = pixel_pos % NUM_COLS;
          lit = (it.pixel_value != 8'h00) ^ set_invert;
          if (lit && r < PANEL_HEIGHT)
            upper_bitmap[c][r] = 1'b1;
          else if (lit)
            lower_bitmap[c][r - PANEL_HEIGHT] = 1'b1;
          pixel_pos++;
        end
        if (it.last_pixel) begin
          add_packet(set_upper_addr, upper_bitmap);
          add_packet(set_lower_addr, lower_bitmap);
          foreach (upper_bitmap[i]) begin
            upper_bitmap[i] = 7'h00;
            lower_bitmap[i] = 7'h00;
          end
          pixel_pos = 0;
          frames_packed++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input logic [1:0] packets = 2'd0, input logic [7:0] addr_a = 8'd0,
                           input logic [7:0] addr_b = 8'd0, input logic [6:0] col_val = 7'd0);
    int unsigned gap;
    logic [6:0]  flat [NUM_COLS];
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    encode_item(it);
    if (typed) begin
      item_beats.delete();
      foreach (flat[i]) flat[i] = col_val;
      if (packets > 0) add_packet(addr_a, flat);
      if (packets > 1) add_packet(addr_b, flat);
    end
    if (item_beats.size() != 0) item_beats[item_beats.size() - 1].last_byte = 1'b1;
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
  endtask

  // Hold the input idle until every expected byte has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_INVERT) ? 32'h1 : 32'hFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= ($urandom() & ~mask) | ({24'd0, value} & mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read back the same register
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if ((got & mask) !== ({24'd0, value} & mask))
      report($sformatf("register %0d reads 0x%h, wrote 0x%h", idx, got & mask, value));
    case (idx)
      REG_INVERT:     set_invert = value[0];
      REG_UPPER_ADDR: set_upper_addr = value;
      REG_LOWER_ADDR: set_lower_addr = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic inv, input logic [7:0] up_addr, input logic [7:0] lo_addr);
    drain();
    // allow a bare pixel beat still in flight to settle
    repeat (8) @(posedge clk);
    cfg_write(REG_INVERT, {7'd0, inv});
    cfg_write(REG_UPPER_ADDR, up_addr);
    cfg_write(REG_LOWER_ADDR, lo_addr);
    settings_used++;
  endtask

  task automatic run_frame(input int unsigned len);
    in_item_t    it;
    int unsigned i;
    no_idle = ($urandom_range(0, 4) == 0);
    for (i = 0; i < len; i++) begin
      // occasional fill or unused command in the middle of the frame
      if ($urandom_range(0, 23) == 0) begin
        it.operation   = op_t'($urandom_range(1, 3));
        it.pixel_value = 8'($urandom_range(0, 255));
        it.last_pixel  = 1'($urandom_range(0, 1));
        send_item(it);
      end
      it.operation   = OP_PIXEL;
      it.pixel_value = draw_pixel();
      it.last_pixel  = (i == len - 1);
      send_item(it);
    end
    if ($urandom_range(0, 7) == 0) drain();
  endtask

  // Result side: stall at random, then check each beat against the oldest expectation
  initial begin
    int unsigned stall;
    out_item_t   got;
    out_item_t   exp_beat;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = out_if.data;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report($sformatf("byte 0x%h arrived with nothing expected", got.out_byte));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (got.out_byte !== exp_beat.out_byte)
          report($sformatf("beat %0d: out_byte 0x%h, expected 0x%h",
                           beats_checked, got.out_byte, exp_beat.out_byte));
        if (got.last_byte !== exp_beat.last_byte)
          report($sformatf("beat %0d: last_byte %b, expected %b",
                           beats_checked, got.last_byte, exp_beat.last_byte));
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned goal;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    foreach (upper_bitmap[i]) begin
      upper_bitmap[i] = 7'h00;
      lower_bitmap[i] = 7'h00;
    end
    pixel_pos = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].packets,
                directed_rows[k].addr0, directed_rows[k].addr1, directed_rows[k].col);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(1'b1, 8'h00, 8'hFF);
        1: set_config(1'b0, 8'hFF, 8'h00);
        2: set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        default: set_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      goal = items_sent + 6;
      while (items_sent < goal) run_frame($urandom_range(1, 12));
      // in the last phase, one long frame that reaches into the lower panel
      case (phase)
        3: run_frame($urandom_range(FRAME_PIXELS / 2 + 1, FRAME_PIXELS / 2 + 8));
        default: ;
      endcase
    end

    drain();
    repeat (16) @(posedge clk);
    if (expected_beats.size() != 0)
      report($sformatf("%0d expected bytes never arrived", expected_beats.size()));
    $display("Sent %0d input beats: %0d frames packed, %0d fill commands, %0d register settings",
             items_sent, frames_packed, fills_sent, settings_used);
    $display("Checked %0d packet bytes, %0d mismatches", beats_checked, errors);
    if (errors == 0)
      $display("flip_dot_frame_packer_core verification clean");
    else
      $display("flip_dot_frame_packer_core verification failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout at %0t", $time);
    $display("flip_dot_frame_packer_core verification failed");
    $finish;
  end

endmodule
